// ----- rtl/exlex_pkg.sv -----
// Types, constants and character helpers shared by the expression lexer.
`default_nettype none

package exlex_pkg;

    // Field widths and saturation limits.
    localparam int POS_WIDTH = 16;
    localparam int LEN_WIDTH = 8;
    localparam logic [LEN_WIDTH-1:0] MAX_TOKEN_LEN = 8'd255;

    // Result buffer sizing: up to four tokens per source byte.
    localparam int MAX_RES = 4;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);
    localparam logic [CNT_W-1:0] MAX_RES_CNT = 3'd4;

    localparam int KW_COUNT = 6;
    localparam logic [KW_COUNT-1:0] KW_ALL = '1;

    typedef logic [POS_WIDTH-1:0] t_pos;
    typedef logic [LEN_WIDTH-1:0] t_len;

    // Token kinds as they leave the block.
    typedef enum logic [3:0] {
        KIND_NUMBER    = 4'd0,
        KIND_VARIABLE  = 4'd1,
        KIND_STATEMENT = 4'd2,
        KIND_BOOLEAN   = 4'd3,
        KIND_OPERATOR  = 4'd4,
        KIND_LOGIC     = 4'd5,
        KIND_LPAREN    = 4'd6,
        KIND_RPAREN    = 4'd7,
        KIND_LCURLY    = 4'd8,
        KIND_RCURLY    = 4'd9,
        KIND_COMPARE   = 4'd10,
        KIND_COMMA     = 4'd11,
        KIND_SEMICOLON = 4'd12,
        KIND_END       = 4'd13,
        KIND_ERROR     = 4'd14
    } t_kind;

    // Pending comparison operator.
    typedef enum logic [2:0] {
        CMP_NONE = 3'd0,
        CMP_EQ   = 3'd1,
        CMP_GT   = 3'd2,
        CMP_LT   = 3'd3,
        CMP_NOT  = 3'd4
    } t_cmp;

    typedef struct packed {
        t_kind      kind;
        t_pos       row;
        t_pos       col;
        t_len       len;
        logic [7:0] sym1;
        logic [7:0] sym2;
        logic [2:0] kw;
    } t_tok;

    typedef struct packed {
        t_tok [MAX_RES-1:0] tok;
        logic [CNT_W-1:0]   cnt;
    } t_buf;

    typedef struct packed {
        t_pos                row;
        t_pos                col;
        t_len                nlen;
        t_len                ilen;
        logic                dec;
        t_cmp                pc;
        logic [KW_COUNT-1:0] kwm;
        logic                halt;
    } t_state;

    // Lexer state plus the tokens produced so far for one byte.
    typedef struct packed {
        t_state st;
        t_buf   ob;
    } t_work;

    localparam t_state ST_RESET = '{
        row:  16'd1,
        col:  16'd1,
        nlen: '0,
        ilen: '0,
        dec:  1'b0,
        pc:   CMP_NONE,
        kwm:  KW_ALL,
        halt: 1'b0
    };

    // Keyword spelling: while, if, else, print, true, false.
    function automatic logic [7:0] f_kw_char(logic [2:0] k, logic [2:0] i);
        logic [39:0] w;
        logic [7:0]  ch;
        unique case (k)
            3'd0:    w = "while";
            3'd1:    w = {"if", 24'h0};
            3'd2:    w = {"else", 8'h0};
            3'd3:    w = "print";
            3'd4:    w = {"true", 8'h0};
            3'd5:    w = "false";
            default: w = '0;
        endcase
        unique case (i)
            3'd0:    ch = w[39:32];
            3'd1:    ch = w[31:24];
            3'd2:    ch = w[23:16];
            3'd3:    ch = w[15:8];
            3'd4:    ch = w[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic t_len f_kw_len(logic [2:0] k);
        t_len l;
        unique case (k)
            3'd0:    l = 8'd5;
            3'd1:    l = 8'd2;
            3'd2:    l = 8'd4;
            3'd3:    l = 8'd5;
            3'd4:    l = 8'd4;
            3'd5:    l = 8'd5;
            default: l = 8'd0;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] f_cmp_sym(t_cmp c);
        logic [7:0] s;
        unique case (c)
            CMP_EQ:  s = "=";
            CMP_GT:  s = ">";
            CMP_LT:  s = "<";
            CMP_NOT: s = "!";
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic f_is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic f_is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic f_is_punct(logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
               c == "(" || c == ")" || c == "{" || c == "}" ||
               c == "|" || c == "^" || c == "&" || c == "," || c == ";";
    endfunction

    function automatic logic f_is_cmp(logic [7:0] c);
        return c == "=" || c == ">" || c == "<" || c == "!";
    endfunction

    function automatic t_kind f_punct_kind(logic [7:0] c);
        t_kind k;
        if (c == "(")                          k = KIND_LPAREN;
        else if (c == ")")                     k = KIND_RPAREN;
        else if (c == "{")                     k = KIND_LCURLY;
        else if (c == "}")                     k = KIND_RCURLY;
        else if (c == "|" || c == "^" || c == "&") k = KIND_LOGIC;
        else if (c == ",")                     k = KIND_COMMA;
        else if (c == ";")                     k = KIND_SEMICOLON;
        else                                   k = KIND_OPERATOR;
        return k;
    endfunction

    function automatic t_cmp f_cmp_code(logic [7:0] c);
        t_cmp p;
        if (c == "=")      p = CMP_EQ;
        else if (c == ">") p = CMP_GT;
        else if (c == "<") p = CMP_LT;
        else               p = CMP_NOT;
        return p;
    endfunction

    // Saturating position add; the increment is at most one length plus one.
    function automatic t_pos f_pos_add(t_pos a, logic [LEN_WIDTH:0] b);
        logic [POS_WIDTH:0] s;
        s = {1'b0, a} + {{(POS_WIDTH - LEN_WIDTH){1'b0}}, b};
        return s[POS_WIDTH] ? '1 : s[POS_WIDTH-1:0];
    endfunction

    function automatic t_len f_len_inc(t_len l);
        return (l < MAX_TOKEN_LEN) ? l + 8'd1 : l;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/expression_lexer_top.sv -----
// Byte-serial expression lexer with an input register and a token buffer.
// Bytes wait in the input register until the token buffer can take their tokens.
// Throughput: one byte per cycle while each byte gives at most one token and the
// token channel is ready; a byte giving n tokens holds the single output port,
// and with it the buffer, until all n have left.
// Reset (synchronous, active low) empties both stages and restores row 1, column 1.
`default_nettype none

module expression_lexer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Source byte channel.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // [7:0] current_char, [15:8] next_char
    input  wire logic        i_s_axis_tuser,  // [0] next_present
    input  wire logic        i_s_axis_tlast,  // end_of_text
    // Token channel.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [15:0] start_row, [31:16] start_col, [39:32] token_length,
    // [47:40] first_symbol, [55:48] second_symbol, [58:56] keyword_id, rest zero
    output logic [63:0]      o_m_axis_tdata,
    output logic [3:0]       o_m_axis_tuser,  // [3:0] token_kind
    output logic             o_m_axis_tlast   // last_of_run
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_cur;
    logic [7:0] r_in_nxt;
    logic       r_in_np;
    logic       r_in_eot;

    // Lexer state and token buffer.
    exlex_pkg::t_state                          r_st;
    exlex_pkg::t_state                          n_st;
    exlex_pkg::t_tok [exlex_pkg::MAX_RES-1:0]   r_tok;
    logic [exlex_pkg::CNT_W-1:0]                r_cnt;
    logic [exlex_pkg::IDX_W-1:0]                r_idx;
    exlex_pkg::t_buf                            n_buf;

    logic            out_fire;
    logic            out_last;
    logic            buf_free;
    logic            load;
    exlex_pkg::t_tok cur_tok;

    // Append one token, dropping any beyond the buffer size.
    function automatic exlex_pkg::t_work f_emit(exlex_pkg::t_work w, exlex_pkg::t_tok t);
        if (w.ob.cnt < exlex_pkg::MAX_RES_CNT) begin
            w.ob.tok[w.ob.cnt[exlex_pkg::IDX_W-1:0]] = t;
            w.ob.cnt = w.ob.cnt + 1'b1;
        end
        return w;
    endfunction

    function automatic exlex_pkg::t_tok f_tok(exlex_pkg::t_kind kind, exlex_pkg::t_pos row,
                                              exlex_pkg::t_pos col, exlex_pkg::t_len len,
                                              logic [7:0] s1, logic [7:0] s2,
                                              logic [2:0] kw);
        exlex_pkg::t_tok t;
        t.kind = kind;
        t.row  = row;
        t.col  = col;
        t.len  = len;
        t.sym1 = s1;
        t.sym2 = s2;
        t.kw   = kw;
        return t;
    endfunction

    // An error token halts the stream until end of text.
    function automatic exlex_pkg::t_work f_fail(exlex_pkg::t_work w, exlex_pkg::t_pos col);
        w = f_emit(w, f_tok(exlex_pkg::KIND_ERROR, w.st.row, col, '0, 8'h00, 8'h00, 3'd0));
        w.st.halt = 1'b1;
        return w;
    endfunction

    // Emit a pending number or word.
    function automatic exlex_pkg::t_work f_flush(exlex_pkg::t_work w, logic at_end);
        logic [2:0]        id;
        logic              found;
        exlex_pkg::t_kind  kind;
        id    = 3'd0;
        found = 1'b0;
        if (w.st.nlen != '0) begin
            w = f_emit(w, f_tok(exlex_pkg::KIND_NUMBER, w.st.row, w.st.col, w.st.nlen,
                                8'h00, 8'h00, 3'd0));
            if (!at_end) begin
                w.st.col = exlex_pkg::f_pos_add(w.st.col, {1'b0, w.st.nlen});
            end
            w.st.nlen = '0;
            w.st.dec  = 1'b0;
        end else if (w.st.ilen != '0) begin
            // First keyword still matching at exactly this length wins.
            for (int k = 0; k < exlex_pkg::KW_COUNT; k++) begin
                if (!found && w.st.kwm[k] && w.st.ilen == exlex_pkg::f_kw_len(k[2:0])) begin
                    id    = k[2:0] + 3'd1;
                    found = 1'b1;
                end
            end
            if (id == 3'd0)      kind = exlex_pkg::KIND_VARIABLE;
            else if (id <= 3'd4) kind = exlex_pkg::KIND_STATEMENT;
            else                 kind = exlex_pkg::KIND_BOOLEAN;
            w = f_emit(w, f_tok(kind, w.st.row, w.st.col, w.st.ilen, 8'h00, 8'h00, id));
            w.st.col  = exlex_pkg::f_pos_add(w.st.col, {1'b0, w.st.ilen});
            w.st.ilen = '0;
            w.st.kwm  = exlex_pkg::KW_ALL;
        end
        return w;
    endfunction

    // A pending compare not followed by '=' stands alone.
    function automatic exlex_pkg::t_work f_resolve(exlex_pkg::t_work w);
        if (w.st.pc == exlex_pkg::CMP_EQ) begin
            w = f_emit(w, f_tok(exlex_pkg::KIND_OPERATOR, w.st.row, w.st.col, 8'd1,
                                "=", 8'h00, 3'd0));
        end else begin
            w = f_emit(w, f_tok(exlex_pkg::KIND_COMPARE, w.st.row, w.st.col, 8'd1,
                                exlex_pkg::f_cmp_sym(w.st.pc), 8'h00, 3'd0));
        end
        w.st.col = exlex_pkg::f_pos_add(w.st.col, 9'd1);
        w.st.pc  = exlex_pkg::CMP_NONE;
        return w;
    endfunction

    // Extend a word and narrow the keyword candidates.
    function automatic exlex_pkg::t_state f_take_ident(exlex_pkg::t_state s, logic [7:0] c);
        for (int k = 0; k < exlex_pkg::KW_COUNT; k++) begin
            if (s.ilen >= exlex_pkg::f_kw_len(k[2:0]) ||
                exlex_pkg::f_kw_char(k[2:0], s.ilen[2:0]) != c) begin
                s.kwm[k] = 1'b0;
            end
        end
        s.ilen = exlex_pkg::f_len_inc(s.ilen);
        return s;
    endfunction

    // Lex the registered byte: next state and all tokens it causes.
    always_comb begin
        exlex_pkg::t_work w;
        exlex_pkg::t_work w_fl;
        logic             skip;
        w.st   = r_st;
        w.ob   = '0;
        w_fl   = '0;
        skip   = 1'b0;
        if (!w.st.halt) begin
            if (w.st.pc != exlex_pkg::CMP_NONE) begin
                if (r_in_cur == "=") begin
                    w = f_emit(w, f_tok(exlex_pkg::KIND_COMPARE, w.st.row, w.st.col, 8'd2,
                                        exlex_pkg::f_cmp_sym(w.st.pc), "=", 3'd0));
                    w.st.col = exlex_pkg::f_pos_add(w.st.col, 9'd2);
                    w.st.pc  = exlex_pkg::CMP_NONE;
                    skip     = 1'b1;
                end else if (w.st.pc == exlex_pkg::CMP_NOT) begin
                    w    = f_fail(w, w.st.col);
                    skip = 1'b1;
                end else begin
                    w = f_resolve(w);
                end
            end
            w_fl = f_flush(w, 1'b0);
            if (!skip) begin
                priority if (r_in_cur == "\n") begin
                    w        = w_fl;
                    w.st.row = exlex_pkg::f_pos_add(w.st.row, 9'd1);
                    w.st.col = 16'd1;
                end else if (r_in_cur == " " || r_in_cur == "\t") begin
                    w        = w_fl;
                    w.st.col = exlex_pkg::f_pos_add(w.st.col, 9'd1);
                end else if (exlex_pkg::f_is_punct(r_in_cur)) begin
                    w = f_emit(w_fl, f_tok(exlex_pkg::f_punct_kind(r_in_cur), w_fl.st.row,
                                           w_fl.st.col, 8'd1, r_in_cur, 8'h00, 3'd0));
                    w.st.col = exlex_pkg::f_pos_add(w.st.col, 9'd1);
                end else if (exlex_pkg::f_is_digit(r_in_cur)) begin
                    if (w.st.ilen != '0) begin
                        w.st = f_take_ident(w.st, r_in_cur);
                    end else if (r_in_np && (exlex_pkg::f_is_alpha(r_in_nxt) ||
                                             r_in_nxt == "_")) begin
                        // A digit run that runs into a letter is malformed.
                        w = f_fail(w, exlex_pkg::f_pos_add(w.st.col,
                                                           {1'b0, w.st.nlen} + 9'd1));
                    end else begin
                        w.st.nlen = exlex_pkg::f_len_inc(w.st.nlen);
                    end
                end else if (r_in_cur == ".") begin
                    if (!(r_in_np && exlex_pkg::f_is_digit(r_in_nxt))) begin
                        if (w.st.ilen != '0) begin
                            w = f_fail(w, exlex_pkg::f_pos_add(w.st.col, {1'b0, w.st.ilen}));
                        end else begin
                            w = f_fail(w, exlex_pkg::f_pos_add(w.st.col,
                                                               {1'b0, w.st.nlen} + 9'd1));
                        end
                    end else if (w.st.dec || w.st.nlen == '0) begin
                        w = f_fail(w, exlex_pkg::f_pos_add(w.st.col, {1'b0, w.st.nlen}));
                    end else begin
                        w.st.dec  = 1'b1;
                        w.st.nlen = exlex_pkg::f_len_inc(w.st.nlen);
                    end
                end else if (exlex_pkg::f_is_alpha(r_in_cur) || r_in_cur == "_") begin
                    if (w.st.nlen != '0) begin
                        w = f_fail(w, exlex_pkg::f_pos_add(w.st.col, {1'b0, w.st.nlen}));
                    end else begin
                        w.st = f_take_ident(w.st, r_in_cur);
                    end
                end else if (exlex_pkg::f_is_cmp(r_in_cur)) begin
                    w       = w_fl;
                    w.st.pc = exlex_pkg::f_cmp_code(r_in_cur);
                end else begin
                    w = f_fail(w, exlex_pkg::f_pos_add(w.st.col, {1'b0, w.st.nlen}));
                end
            end
        end
        // End of text: flush everything, add END unless halted, then start over.
        if (r_in_eot) begin
            if (!w.st.halt) begin
                w = f_flush(w, 1'b1);
                if (w.st.pc == exlex_pkg::CMP_NOT) begin
                    w = f_fail(w, w.st.col);
                end else if (w.st.pc != exlex_pkg::CMP_NONE) begin
                    w = f_resolve(w);
                end
                if (!w.st.halt) begin
                    w = f_emit(w, f_tok(exlex_pkg::KIND_END, w.st.row, w.st.col, '0,
                                        8'h00, 8'h00, 3'd0));
                end
            end
            w.st = exlex_pkg::ST_RESET;
        end
        n_st  = w.st;
        n_buf = w.ob;
    end

    // Handshake control: the buffer takes a new byte once its last token leaves.
    assign cur_tok         = r_tok[r_idx];
    assign o_m_axis_tvalid = (r_cnt != '0);
    assign out_last        = ({1'b0, r_idx} == r_cnt - 1'b1);
    assign out_fire        = o_m_axis_tvalid && i_m_axis_tready;
    assign buf_free        = (r_cnt == '0) || (out_fire && out_last);
    assign load            = r_in_valid && buf_free;
    assign o_s_axis_tready = !r_in_valid || load;

    assign o_m_axis_tdata  = {5'b0, cur_tok.kw, cur_tok.sym2, cur_tok.sym1, cur_tok.len,
                              cur_tok.col, cur_tok.row};
    assign o_m_axis_tuser  = cur_tok.kind;
    assign o_m_axis_tlast  = out_last;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= '0;
            r_idx      <= '0;
            r_st       <= exlex_pkg::ST_RESET;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (load) begin
                r_st  <= n_st;
                r_cnt <= n_buf.cnt;
                r_idx <= '0;
            end else if (out_fire) begin
                if (out_last) begin
                    r_cnt <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_cur <= i_s_axis_tdata[7:0];
            r_in_nxt <= i_s_axis_tdata[15:8];
            r_in_np  <= i_s_axis_tuser;
            r_in_eot <= i_s_axis_tlast;
        end
        if (load) begin
            r_tok <= n_buf.tok;
        end
    end

    // A halted stream gives no tokens until the end-of-text byte.
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_st.halt && !r_in_eot |=> r_cnt == '0)
        else $error("halted lexer produced a token");

    // The end-of-text byte always leaves the lexer in its reset state.
    a_eot_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_in_eot |=> r_st == exlex_pkg::ST_RESET)
        else $error("lexer state not restored after end of text");

    // END and error tokens always close the run of their byte.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == exlex_pkg::KIND_END ||
                            o_m_axis_tuser == exlex_pkg::KIND_ERROR) |-> o_m_axis_tlast)
        else $error("END or error token not last of its run");

    // The buffer never holds more tokens than it has slots.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_cnt <= exlex_pkg::MAX_RES_CNT && r_idx == '0)
        else $error("token buffer count out of range after load");

endmodule

`default_nettype wire
